/* hdl/assert_macros.svh */
// Assertion macros shared by the noise block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* hdl/fvn_pkg.sv */
// Shared types and constants of the fractal value noise block.
`timescale 1ns / 1ps
package fvn_pkg;
	localparam logic [31:0] HASH_MUL_A = 32'd374761393;
	localparam logic [31:0] HASH_MUL_B = 32'd668265263;
	localparam logic [31:0] HASH_MUL_C = 32'd1274126177;
	localparam int HASH_SHIFT = 13;
	localparam int SEED_STEP = 57;

	localparam logic [31:0] FREQ_ONE = 32'd4096;
	localparam logic [15:0] AMP_ONE = 16'd32768;

	localparam logic [1:0] REG_OCTAVES = 2'd0;
	localparam logic [1:0] REG_LACUNARITY = 2'd1;
	localparam logic [1:0] REG_GAIN = 2'd2;
	localparam logic [1:0] REG_SEED = 2'd3;

	localparam int QUOT_W = 16;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0] freq;
		logic [15:0] amp;
	} pt_t;
endpackage

/* hdl/fbm_value_noise_2d_unit.sv */
// Top level of the fractal value noise block: registers, octave chain, divider.
//
// Input items (x_coord, y_coord, signed Q16.16) enter on in_valid/in_stall,
// and each gives one noise_value (Q0.16) on out_valid/out_stall.
// The datapath is a row of MAX_OCTAVES octave cells of seven stages each,
// followed by a row of sixteen divider cells of one stage each; every cell
// hands its item to the next one in every cycle in which the row does not hold.
// One item is taken per cycle while the row does not hold, set by the
// one-stage step of each cell.
// Octaves at or past octave_count (zero taken as one, capped at MAX_OCTAVES)
// still flow through their cells but add nothing to the sums.
// The registers are written through wr_en/wr_index/wr_data; the user must
// write them only while no item is in flight: the block does not enforce it.
// Reset clears all valid flags and loads the register defaults; no item is
// in flight after reset.
// When the receiver stalls a waiting result, the whole row holds and
// in_stall rises in the same cycle; it falls as soon as the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbm_value_noise_2d_unit #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [1:0] wr_index,
	input  logic [31:0] wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] noise_value
);
	localparam int NW = $clog2(MAX_OCTAVES + 1);
	localparam int ASW = 16 + NW;
	localparam int WSW = 32 + NW;
	localparam int QW = fvn_pkg::QUOT_W;

	logic [3:0] octave_count_q;
	logic [15:0] lacunarity_q, gain_q;
	logic [31:0] seed_q;
	logic [NW-1:0] oct_n;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= 4'd4;
			lacunarity_q <= 16'd8192;
			gain_q <= 16'd16384;
			seed_q <= 32'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				fvn_pkg::REG_OCTAVES: octave_count_q <= wr_data[3:0];
				fvn_pkg::REG_LACUNARITY: lacunarity_q <= wr_data[15:0];
				fvn_pkg::REG_GAIN: gain_q <= wr_data[15:0];
				fvn_pkg::REG_SEED: seed_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (octave_count_q == 4'd0) oct_n = NW'(1);
		else if (32'(octave_count_q) > MAX_OCTAVES) oct_n = NW'(MAX_OCTAVES);
		else oct_n = NW'(octave_count_q);
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic c_vld [0:MAX_OCTAVES];
	fvn_pkg::pt_t c_pt [0:MAX_OCTAVES];
	logic [WSW-1:0] c_wsum [0:MAX_OCTAVES];
	logic [ASW-1:0] c_asum [0:MAX_OCTAVES];

	assign c_vld[0] = in_valid;
	assign c_pt[0] = '{x: x_coord, y: y_coord, freq: fvn_pkg::FREQ_ONE, amp: fvn_pkg::AMP_ONE};
	assign c_wsum[0] = '0;
	assign c_asum[0] = '0;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fvn_octave_cell #(.IDX(i), .NW(NW), .WSW(WSW), .ASW(ASW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.lacunarity(lacunarity_q), .gain(gain_q), .seed(seed_q), .oct_n(oct_n),
			.in_vld(c_vld[i]), .in_pt(c_pt[i]), .in_wsum(c_wsum[i]), .in_asum(c_asum[i]),
			.out_vld(c_vld[i+1]), .out_pt(c_pt[i+1]),
			.out_wsum(c_wsum[i+1]), .out_asum(c_asum[i+1])
		);
	end

	logic d_vld [0:QW];
	logic [WSW-1:0] d_rem [0:QW];
	logic [ASW-1:0] d_div [0:QW];
	logic [QW-1:0] d_quot [0:QW];

	assign d_vld[0] = c_vld[MAX_OCTAVES];
	assign d_rem[0] = c_wsum[MAX_OCTAVES];
	assign d_div[0] = c_asum[MAX_OCTAVES];
	assign d_quot[0] = '0;

	// Quotient bits are settled from the top bit down.
	for (genvar j = 0; j < QW; j++) begin : g_div
		fvn_div_cell #(.K(QW - 1 - j), .WSW(WSW), .ASW(ASW)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_vld(d_vld[j]), .in_rem(d_rem[j]), .in_div(d_div[j]), .in_quot(d_quot[j]),
			.out_vld(d_vld[j+1]), .out_rem(d_rem[j+1]), .out_div(d_div[j+1]),
			.out_quot(d_quot[j+1])
		);
	end

	assign out_valid = d_vld[QW];
	assign noise_value = d_quot[QW];

	`CHK_IMPLY(a_first_amp, clk, arst_n, c_vld[1], c_asum[1] == ASW'(fvn_pkg::AMP_ONE), "first octave amplitude sum is not one")
	`CHK_IMPLY(a_div_nonzero, clk, arst_n, d_vld[0], d_div[0] >= ASW'(fvn_pkg::AMP_ONE), "divisor below first amplitude")
	`CHK_IMPLY(a_quot_fits, clk, arst_n, d_vld[0], d_rem[0] < (WSW'(d_div[0]) << QW), "weighted sum overflows the quotient")
endmodule

/* hdl/fvn_octave_cell.sv */
// One octave of the noise chain: scale, hash, fade, blend and accumulate.
`timescale 1ns / 1ps
module fvn_octave_cell #(
	parameter int IDX = 0,
	parameter int NW = 4,
	parameter int WSW = 36,
	parameter int ASW = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [15:0] lacunarity,
	input  logic [15:0] gain,
	input  logic [31:0] seed,
	input  logic [NW-1:0] oct_n,
	input  logic in_vld,
	input  fvn_pkg::pt_t in_pt,
	input  logic [WSW-1:0] in_wsum,
	input  logic [ASW-1:0] in_asum,
	output logic out_vld,
	output fvn_pkg::pt_t out_pt,
	output logic [WSW-1:0] out_wsum,
	output logic [ASW-1:0] out_asum
);
	localparam int STG = 7;

	logic signed [64:0] px_w, py_w;
	logic [47:0] nf_w;
	logic [31:0] na_w;
	logic [31:0] nf_sat, seed_oct;
	logic [15:0] na_sat;
	logic active;

	assign px_w = $signed(in_pt.x) * $signed({1'b0, in_pt.freq});
	assign py_w = $signed(in_pt.y) * $signed({1'b0, in_pt.freq});
	assign nf_w = in_pt.freq * lacunarity;
	assign na_w = in_pt.amp * gain;
	assign nf_sat = (nf_w[47:44] != 4'd0) ? 32'hFFFF_FFFF : nf_w[43:12];
	assign na_sat = na_w[31] ? 16'hFFFF : na_w[30:15];
	assign seed_oct = seed + 32'(fvn_pkg::SEED_STEP * IDX);
	assign active = NW'(IDX) < oct_n;

	fvn_pkg::pt_t pt_s [1:STG];
	logic [15:0] amp_s [1:STG];
	logic [WSW-1:0] wsum_s [1:STG];
	logic [ASW-1:0] asum_s [1:STG];
	logic vld_s [1:STG];

	logic [31:0] cx_s1, cy_s1;
	logic [15:0] fx_s1, fy_s1;
	logic [31:0] ma_s2, mb_s2, mc_s2, t2x_s2, t2y_s2;
	logic [15:0] fx_s2, fy_s2;
	logic [31:0] g_s3 [4];
	logic [31:0] cfx_s3, cfy_s3;
	logic [20:0] qx_s3, qy_s3;
	logic [15:0] v_s4 [4];
	logic [16:0] wx_s4, wy_s4, wy_s5;
	logic [15:0] top_s5, bot_s5, o_s6;

	logic [31:0] h00;
	logic [31:0] hc [4];
	logic [47:0] t3x, t3y;
	logic [36:0] qx_w, qy_w;
	logic [52:0] wx_w, wy_w;
	logic [33:0] top_w, bot_w, o_w;

	always_comb begin
		h00 = ma_s2 + mb_s2 + mc_s2;
		hc[0] = h00;
		hc[1] = h00 + fvn_pkg::HASH_MUL_A;
		hc[2] = h00 + fvn_pkg::HASH_MUL_B;
		hc[3] = h00 + fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_MUL_B;
		t3x = t2x_s2 * fx_s2;
		t3y = t2y_s2 * fy_s2;
		// The quintic's quadratic factor is positive over the whole unit range.
		qx_w = 37'd6 * t2x_s2 + (37'd10 << 32) - ((37'd15 * fx_s2) << 16);
		qy_w = 37'd6 * t2y_s2 + (37'd10 << 32) - ((37'd15 * fy_s2) << 16);
		wx_w = cfx_s3 * qx_s3;
		wy_w = cfy_s3 * qy_s3;
		top_w = v_s4[0] * (17'h10000 - wx_s4) + v_s4[1] * wx_s4;
		bot_w = v_s4[2] * (17'h10000 - wx_s4) + v_s4[3] * wx_s4;
		o_w = top_s5 * (17'h10000 - wy_s5) + bot_s5 * wy_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= STG; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int i = 2; i <= STG; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s[1] <= '{x: in_pt.x, y: in_pt.y, freq: nf_sat, amp: na_sat};
			amp_s[1] <= in_pt.amp;
			wsum_s[1] <= in_wsum;
			asum_s[1] <= in_asum;
			for (int i = 2; i <= STG; i++) begin
				pt_s[i] <= pt_s[i-1];
				amp_s[i] <= amp_s[i-1];
			end
			for (int i = 2; i < STG; i++) begin
				wsum_s[i] <= wsum_s[i-1];
				asum_s[i] <= asum_s[i-1];
			end

			cx_s1 <= px_w[59:28];
			cy_s1 <= py_w[59:28];
			fx_s1 <= px_w[27:12];
			fy_s1 <= py_w[27:12];

			ma_s2 <= cx_s1 * fvn_pkg::HASH_MUL_A;
			mb_s2 <= cy_s1 * fvn_pkg::HASH_MUL_B;
			mc_s2 <= seed_oct * fvn_pkg::HASH_MUL_C;
			t2x_s2 <= fx_s1 * fx_s1;
			t2y_s2 <= fy_s1 * fy_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;

			for (int k = 0; k < 4; k++) g_s3[k] <= hc[k] ^ (hc[k] >> fvn_pkg::HASH_SHIFT);
			cfx_s3 <= t3x[47:16];
			cfy_s3 <= t3y[47:16];
			qx_s3 <= qx_w[36:16];
			qy_s3 <= qy_w[36:16];

			// Only the low half of the final hash product is kept.
			for (int k = 0; k < 4; k++) v_s4[k] <= 16'(g_s3[k][15:0] * fvn_pkg::HASH_MUL_C[15:0]);
			wx_s4 <= wx_w[48:32];
			wy_s4 <= wy_w[48:32];

			top_s5 <= top_w[31:16];
			bot_s5 <= bot_w[31:16];
			wy_s5 <= wy_s4;

			o_s6 <= o_w[31:16];

			if (active) begin
				wsum_s[STG] <= wsum_s[STG-1] + WSW'(amp_s[STG-1]) * WSW'(o_s6);
				asum_s[STG] <= asum_s[STG-1] + ASW'(amp_s[STG-1]);
			end else begin
				wsum_s[STG] <= wsum_s[STG-1];
				asum_s[STG] <= asum_s[STG-1];
			end
		end
	end

	assign out_vld = vld_s[STG];
	assign out_pt = pt_s[STG];
	assign out_wsum = wsum_s[STG];
	assign out_asum = asum_s[STG];
endmodule

/* hdl/fvn_div_cell.sv */
// One restoring step of the normalizing divider, settling one quotient bit.
`timescale 1ns / 1ps
module fvn_div_cell #(
	parameter int K = 0,
	parameter int WSW = 36,
	parameter int ASW = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [WSW-1:0] in_rem,
	input  logic [ASW-1:0] in_div,
	input  logic [fvn_pkg::QUOT_W-1:0] in_quot,
	output logic out_vld,
	output logic [WSW-1:0] out_rem,
	output logic [ASW-1:0] out_div,
	output logic [fvn_pkg::QUOT_W-1:0] out_quot
);
	logic [WSW-1:0] dsh;
	logic fits;
	logic vld_s1;
	logic [WSW-1:0] rem_s1;
	logic [ASW-1:0] div_s1;
	logic [fvn_pkg::QUOT_W-1:0] quot_s1;

	assign dsh = WSW'(in_div) << K;
	assign fits = in_rem >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= fits ? in_rem - dsh : in_rem;
			div_s1 <= in_div;
			quot_s1 <= in_quot | (fvn_pkg::QUOT_W'(fits) << K);
		end
	end

	assign out_vld = vld_s1;
	assign out_rem = rem_s1;
	assign out_div = div_s1;
	assign out_quot = quot_s1;
endmodule
